>>> rtl/core/positional_list_engine_macros.svh
// assertion macros for the positional list engine
// no dependencies; taken in by the files that check their own logic
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// clocked check, masked while reset is asserted
`define PLE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ple_pkg.sv
// shared types and constants for the positional list engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ple_pkg;

    // list store geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = 7;
    localparam int DATA_W   = 32;

    localparam logic [COUNT_W-1:0] CAP_COUNT    = COUNT_W'(CAPACITY);
    localparam logic [DATA_W-1:0]  READ_INVALID = '1;

    // operation codes carried on the input side
    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_INS_HEAD = 3'd1,
        OP_INS_TAIL = 3'd2,
        OP_INS_AT   = 3'd3,
        OP_DELETE   = 3'd4
    } opcode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ_WAIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DONE
    } state_t;

    // one access to the list store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // one result item
    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        status_t                  status;
        logic [COUNT_W-1:0]       entry_count;
    } result_t;

endpackage

>>> rtl/core/positional_list_engine.sv
// top level of the positional list engine: stream ports and result register
// depends on ple_pkg, ple_ctrl and ple_ram
`timescale 1ns / 1ps

// Bounded ordered list of up to 64 signed 32-bit entries, kept in a store with one write
// and one read port. Each input transfer carries one operation (read, insert at head,
// insert at tail, insert before a position, delete at a position) and produces exactly
// one result transfer with the read value, a status and the entry count. One
// item is handled at a time: s_tready is high only while the sequencer is idle.
// A read, a rejected operation or an append needs no shift; an insert or a delete at
// position p moves each entry behind p by one slot, in a read state and then a write
// state per entry, because every entry that moves goes through the store's one read
// and one write port in turn. The result sits in an output register, so the next
// item is taken while it waits. The store needs no clearing after reset.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[6:0], item_value[38:7], zero pad
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], status[33:32],
                                   // entry_count[40:34], zero pad
);

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              m_tvalid_reg;
    result_t           out_reg;

    ple_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_opcode   (s_tuser),
        .in_position (s_tdata[6:0]),
        .in_value    (s_tdata[38:7]),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    ple_ram u_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    // pack the result transfer
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_reg.entry_count, out_reg.status, out_reg.read_value};

endmodule

>>> rtl/core/ple_ram.sv
// list store: one write port and one registered read port
// depends on ple_pkg for depth, widths and the access struct
`timescale 1ns / 1ps

module ple_ram
    import ple_pkg::*;
(
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_reg[req.waddr] <= req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ple_ctrl.sv
// sequencer: decodes one operation and walks the shift loop over the store
// depends on ple_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "positional_list_engine_macros.svh"

module ple_ctrl
    import ple_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               in_opcode,
    input  logic [COUNT_W-1:0]       in_position,
    input  logic signed [DATA_W-1:0] in_value,
    output mem_req_t                 mem_req,
    input  logic [DATA_W-1:0]        mem_rdata,
    output logic                     res_valid,
    input  logic                     res_ready,
    output result_t                  res
);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [2:0]         op_reg, op_next;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0]  rval_reg, rval_next;
    status_t            st_reg, st_next;

    // shared index unit: one step and one compare per cycle
    logic               is_delete;
    logic [COUNT_W-1:0] idx_step;
    logic [COUNT_W-1:0] ins_pos;

    assign is_delete = (opcode_t'(op_reg) == OP_DELETE);
    assign idx_step  = is_delete ? COUNT_W'(idx_reg + 1'b1) : COUNT_W'(idx_reg - 1'b1);

    // target position of an insert
    always_comb begin
        case (opcode_t'(op_reg))
            OP_INS_HEAD: ins_pos = '0;
            OP_INS_TAIL: ins_pos = count_reg;
            default:     ins_pos = pos_reg;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // operation and result payload
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        rval_reg <= rval_next;
        st_reg   <= st_next;
    end

    // next state and store accesses
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        rval_next     = rval_reg;
        st_next       = st_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[ADDR_W-1:0];
        mem_req.wdata = mem_rdata;
        mem_req.raddr = idx_step[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next    = in_opcode;
                    pos_next   = in_position;
                    val_next   = in_value;
                    state_next = S_CHECK;
                end
            end

            S_CHECK: begin
                rval_next  = READ_INVALID;
                st_next    = ST_DONE;
                state_next = S_DONE;
                case (opcode_t'(op_reg))
                    OP_READ: begin
                        mem_req.raddr = pos_reg[ADDR_W-1:0];
                        if (pos_reg < count_reg) begin
                            state_next = S_READ_WAIT;
                        end else begin
                            st_next = ST_RANGE;
                        end
                    end
                    OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                        if (opcode_t'(op_reg) == OP_INS_AT && pos_reg > count_reg) begin
                            st_next = ST_RANGE;
                        end else if (count_reg == CAP_COUNT) begin
                            st_next = ST_FULL;
                        end else begin
                            pos_next = ins_pos;
                            idx_next = count_reg;
                            state_next = (count_reg == ins_pos) ? S_PUT : S_SHIFT_RD;
                        end
                    end
                    OP_DELETE: begin
                        if (pos_reg >= count_reg) begin
                            st_next = ST_RANGE;
                        end else if (COUNT_W'(pos_reg + 1'b1) == count_reg) begin
                            count_next = COUNT_W'(count_reg - 1'b1);
                        end else begin
                            idx_next   = pos_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    default: begin
                        st_next = ST_DONE;
                    end
                endcase
            end

            S_READ_WAIT: begin
                rval_next  = mem_rdata;
                state_next = S_DONE;
            end

            // fetch the neighbor that moves into idx
            S_SHIFT_RD: begin
                state_next = S_SHIFT_WR;
            end

            // move the fetched entry and step the index
            S_SHIFT_WR: begin
                mem_req.we = 1'b1;
                idx_next   = idx_step;
                if (is_delete) begin
                    if (COUNT_W'(idx_step + 1'b1) == count_reg) begin
                        count_next = COUNT_W'(count_reg - 1'b1);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SHIFT_RD;
                    end
                end else begin
                    state_next = (idx_step == pos_reg) ? S_PUT : S_SHIFT_RD;
                end
            end

            // drop the new value into its slot
            S_PUT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg[ADDR_W-1:0];
                mem_req.wdata = val_reg;
                count_next    = COUNT_W'(count_reg + 1'b1);
                state_next    = S_DONE;
            end

            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.read_value  = rval_reg;
    assign res.status      = st_reg;
    assign res.entry_count = count_reg;

    // checks on the sequencer
    `PLE_ASSERT(a_count_cap, aclk, aresetn, count_reg <= CAP_COUNT, "entry count above capacity")
    `PLE_ASSERT(a_idle_count, aclk, aresetn, (state_reg == S_IDLE) |=> $stable(count_reg), "count moved while idle")
    `PLE_ASSERT(a_write_state, aclk, aresetn, mem_req.we |-> (state_reg == S_SHIFT_WR || state_reg == S_PUT), "store written outside a shift or put")
    `PLE_ASSERT(a_done_hold, aclk, aresetn, (res_valid && !res_ready) |=> (res_valid && $stable(count_reg)), "result dropped before transfer")

endmodule
